// File: hdl/lgs_pkg.sv
`timescale 1ns / 1ps

package lgs_pkg;

   // Configuration register indexes
   typedef enum logic [0:0] {
      CSR_GRID_WIDTH  = 1'b0,
      CSR_GRID_HEIGHT = 1'b1
   } csr_index_type;

   localparam int CSR_DATA_W  = 11;
   localparam int COORD_W     = 10;
   localparam int GREEN_W     = 8;
   localparam int COUNT_W     = 5;   // weighted count 0..16
   localparam int MIN_SIZE    = 3;
   localparam int CENTRE_WEIGHT = 8;

   // Weighted counts that give a live cell: born on 3, survive on 2 or 3
   localparam logic [COUNT_W-1:0] COUNT_BORN       = 5'd3;
   localparam logic [COUNT_W-1:0] COUNT_SURVIVE_LO = 5'd10;
   localparam logic [COUNT_W-1:0] COUNT_SURVIVE_HI = 5'd11;

   // Line store entry layout
   localparam int LINE_W     = 2;
   localparam int LINE_UPPER = 1;
   localparam int LINE_MID   = 0;

   // Per-cell sideband carried through the stencil stage
   typedef struct packed {
      logic               alive;
      logic               interior;
      logic               last;
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] row;
   } stage_type;

   function automatic logic [GREEN_W-1:0] green_of(input logic [COUNT_W-1:0] count);
      logic [GREEN_W-1:0] level;
      case (count)
         5'd0, 5'd7:          level = 8'h00;
         5'd1, 5'd8:          level = 8'h40;
         5'd2, 5'd9:          level = 8'h60;
         5'd3, 5'd10:         level = 8'h80;
         5'd4, 5'd11:         level = 8'hA0;
         5'd5, 5'd12:         level = 8'hC0;
         5'd6, 5'd13:         level = 8'hE0;
         5'd14, 5'd15, 5'd16: level = 8'hFF;
         default:             level = 8'h00;
      endcase
      return level;
   endfunction

endpackage

// File: hdl/lgs_ram.sv
`timescale 1ns / 1ps

module lgs_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/lgs_stencil.sv
`timescale 1ns / 1ps

module lgs_stencil import lgs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               restart,
   input  logic               advance,
   input  logic               bottom,
   input  logic               top,
   input  logic               mid,
   output logic               next_alive,
   output logic [GREEN_W-1:0] green_level
);

   // bit0 top, bit1 middle, bit2 bottom; low triple is the left column
   logic [5:0]         window_ff;
   logic [5:0]         window_in;
   logic [2:0]         new_col;
   logic [2:0]         left_col;
   logic [2:0]         centre_col;
   logic [COUNT_W-1:0] count;

   assign new_col    = {bottom, mid, top};
   assign left_col   = window_ff[2:0];
   assign centre_col = window_ff[5:3];

   assign count = COUNT_W'(left_col[0]) + COUNT_W'(left_col[1]) + COUNT_W'(left_col[2])
                + COUNT_W'(new_col[0]) + COUNT_W'(new_col[1]) + COUNT_W'(new_col[2])
                + COUNT_W'(centre_col[0]) + COUNT_W'(centre_col[2])
                + (centre_col[1] ? COUNT_W'(CENTRE_WEIGHT) : COUNT_W'(0));

   assign next_alive  = count inside {COUNT_BORN, COUNT_SURVIVE_LO, COUNT_SURVIVE_HI};
   assign green_level = green_of(count);

   always_comb begin
      window_in = window_ff;
      if (restart) begin
         window_in = '0;
      end else if (advance) begin
         window_in = {new_col, centre_col};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else begin
         window_ff <= window_in;
      end
   end

endmodule

// File: hdl/life_generation_stencil.sv
`timescale 1ns / 1ps

// Channel  Dir  Handshake           Word
// req_     in   req_valid/req_stall  req_cell_alive
// rsp_     out  rsp_valid/rsp_stall  rsp_next_alive, rsp_green_level, rsp_cell_column,
//                                    rsp_cell_row, rsp_frame_last
// csr_     in   csr_valid/csr_ready  csr_index, csr_data
//
// One cell word per clock sustained while rsp_stall is low.
// Each result passes the registered read of the line store RAM, then the result register.
// Synchronous active-high reset clears counters, window and valids; the line store
// is not cleared, as rows 0 and 1 of each generation fill it before a read of it feeds a result.
// Output stall backs up through the stencil stage to req_stall; the output
// register lets a new cell in while a finished word waits.
module life_generation_stencil import lgs_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   // cell stream
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_cell_alive,
   // result stream
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_next_alive,
   output logic [GREEN_W-1:0]    rsp_green_level,
   output logic [COORD_W-1:0]    rsp_cell_column,
   output logic [COORD_W-1:0]    rsp_cell_row,
   output logic                  rsp_frame_last,
   // register writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   // Reset size is 1024, clamped to the build limits
   localparam int RST_W_LAST = (1024 > MAX_WIDTH)  ? MAX_WIDTH - 1  : 1023;
   localparam int RST_H_LAST = (1024 > MAX_HEIGHT) ? MAX_HEIGHT - 1 : 1023;

   // ---------------- configuration: stored as clamped last index ----------
   logic [COL_W-1:0] w_last_ff, w_last_in;
   logic [ROW_W-1:0] h_last_ff, h_last_in;
   logic             csr_write;
   logic [CSR_DATA_W-1:0] csr_m1;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;
   assign csr_m1    = csr_data - CSR_DATA_W'(1);

   always_comb begin
      w_last_in = w_last_ff;
      h_last_in = h_last_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_GRID_WIDTH: begin
               if (32'(csr_data) < MIN_SIZE) begin
                  w_last_in = COL_W'(MIN_SIZE - 1);
               end else if (32'(csr_data) > MAX_WIDTH) begin
                  w_last_in = COL_W'(MAX_WIDTH - 1);
               end else begin
                  w_last_in = COL_W'(csr_m1);
               end
            end
            CSR_GRID_HEIGHT: begin
               if (32'(csr_data) < MIN_SIZE) begin
                  h_last_in = ROW_W'(MIN_SIZE - 1);
               end else if (32'(csr_data) > MAX_HEIGHT) begin
                  h_last_in = ROW_W'(MAX_HEIGHT - 1);
               end else begin
                  h_last_in = ROW_W'(csr_m1);
               end
            end
            default: begin
               w_last_in = w_last_ff;
            end
         endcase
      end
   end

   // ---------------- handshake ----------------
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic req_accept, s1_advance, rsp_taken;

   assign rsp_taken  = rsp_valid_ff & ~rsp_stall;
   assign s1_advance = s1_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall  = s1_valid_ff & ~s1_advance;
   assign req_accept = req_valid & ~req_stall;

   // ---------------- raster position ----------------
   logic [COL_W-1:0] col_ff, col_in, col_m1;
   logic [ROW_W-1:0] row_ff, row_in, row_m1;
   logic             col_end, row_end;

   assign col_end = (col_ff == w_last_ff);
   assign row_end = (row_ff == h_last_ff);
   assign col_m1  = col_ff - COL_W'(1);
   assign row_m1  = row_ff - ROW_W'(1);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_write) begin
         col_in = '0;
         row_in = '0;
      end else if (req_accept) begin
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   // ---------------- stage 1: line store read in flight ----------------
   stage_type        s1_ff, s1_in;
   logic [COL_W-1:0] s1_addr_ff;

   always_comb begin
      s1_in.alive    = req_cell_alive;
      // interior cell sits one up and one left of the incoming cell
      s1_in.interior = (col_ff >= COL_W'(2)) && (row_ff >= ROW_W'(2));
      s1_in.last     = col_end & row_end;
      s1_in.column   = COORD_W'(col_m1);
      s1_in.row      = COORD_W'(row_m1);
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   // Both line stores share one entry: upper row and middle row of a column.
   // Read on accept, written back shifted when the cell leaves stage 1. The
   // same column is not read again until a full row later, so no bypass.
   logic [LINE_W-1:0] line_rd;
   logic              line_top, line_mid;

   assign line_top = line_rd[LINE_UPPER];
   assign line_mid = line_rd[LINE_MID];

   lgs_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_advance),
      .wr_addr (s1_addr_ff),
      .wr_data ({line_mid, s1_ff.alive}),
      .rd_en   (req_accept),
      .rd_addr (col_ff),
      .rd_data (line_rd)
   );

   logic               st_alive;
   logic [GREEN_W-1:0] st_green;

   lgs_stencil u_stencil (
      .clock       (clock),
      .reset       (reset),
      .restart     (csr_write),
      .advance     (s1_advance),
      .bottom      (s1_ff.alive),
      .top         (line_top),
      .mid         (line_mid),
      .next_alive  (st_alive),
      .green_level (st_green)
   );

   // ---------------- result register ----------------
   logic               out_alive_ff;
   logic [GREEN_W-1:0] out_green_ff;
   logic [COORD_W-1:0] out_col_ff, out_row_ff;
   logic               out_last_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance) begin
         rsp_valid_in = s1_ff.interior;   // edge cells give no word
      end else if (rsp_taken) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_last_ff    <= COL_W'(RST_W_LAST);
         h_last_ff    <= ROW_W'(RST_H_LAST);
         col_ff       <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         w_last_ff    <= w_last_in;
         h_last_ff    <= h_last_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ff      <= s1_in;
         s1_addr_ff <= col_ff;
      end
      if (s1_advance) begin
         out_alive_ff <= st_alive;
         out_green_ff <= st_green;
         out_col_ff   <= s1_ff.column;
         out_row_ff   <= s1_ff.row;
         out_last_ff  <= s1_ff.last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_next_alive  = out_alive_ff;
   assign rsp_green_level = out_green_ff;
   assign rsp_cell_column = out_col_ff;
   assign rsp_cell_row    = out_row_ff;
   assign rsp_frame_last  = out_last_ff;

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

// Testbench for the life stencil: one cell word per handshake goes in, one result word
// per interior cell comes out.
module tb;
   import lgs_pkg::*;

   localparam int GRID_MAX     = 1024;
   localparam int SETTLE_TICKS = 8;      // margin after the last result is taken; ample
   localparam int RANDOM_CELLS = 1400;
   localparam int TALL_ROWS    = 100;
   localparam int WAIT_MAX     = 18;

   // Green level per weighted count, entry 0 in the low byte
   localparam logic [17*GREEN_W-1:0] GREEN_LUT = {
      8'hFF, 8'hFF, 8'hFF,
      8'hE0, 8'hC0, 8'hA0, 8'h80, 8'h60, 8'h40, 8'h00,
      8'hE0, 8'hC0, 8'hA0, 8'h80, 8'h60, 8'h40, 8'h00
   };

   typedef struct packed {
      logic               next_alive;
      logic [GREEN_W-1:0] green;
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] row;
      logic               last;
   } cell_result_type;

   // ---------------------------------------------------------------- DUT ports
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_cell_alive = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_next_alive;
   logic [GREEN_W-1:0]    rsp_green_level;
   logic [COORD_W-1:0]    rsp_cell_column;
   logic [COORD_W-1:0]    rsp_cell_row;
   logic                  rsp_frame_last;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   csr_index_type         csr_index = CSR_GRID_WIDTH;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // ---------------------------------------------------------------- bench state
   logic            cell_queue[$];       // cell words waiting for the driver
   cell_result_type due_cells[$];        // results owed by the block, oldest first
   int unsigned  cells_sent = 0;
   int unsigned  cells_taken = 0;
   bit           failed = 1'b0;
   bit           req_taken = 1'b0;
   bit           rsp_taken = 1'b0;
   bit           req_calm = 1'b0;
   bit           rsp_calm = 1'b0;
   int unsigned  req_hold = 0;
   int unsigned  stall_left = 0;

   // Predictor copy of the block's registers and stencil state
   logic [CSR_DATA_W-1:0] grid_w;
   logic [CSR_DATA_W-1:0] grid_h;
   int unsigned           col_pos;
   int unsigned           row_pos;
   logic                  line_upper [GRID_MAX];
   logic                  line_middle[GRID_MAX];
   logic [5:0]            stencil_window;   // [2:0] left column, [5:3] centre column

   always #5 clock = ~clock;

   life_generation_stencil uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cell_alive (req_cell_alive),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_next_alive (rsp_next_alive),
      .rsp_green_level(rsp_green_level),
      .rsp_cell_column(rsp_cell_column),
      .rsp_cell_row   (rsp_cell_row),
      .rsp_frame_last (rsp_frame_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   // ---------------------------------------------------------------- predictor
   function automatic int unsigned clamp_size(input logic [CSR_DATA_W-1:0] v);
      if (v < MIN_SIZE) return MIN_SIZE;
      if (v > GRID_MAX) return GRID_MAX;
      return 32'(v);
   endfunction

   // Any register write starts a fresh generation at row 0, column 0
   function automatic void apply_reg(input csr_index_type idx,
                                     input logic [CSR_DATA_W-1:0] value);
      if (idx == CSR_GRID_WIDTH) grid_w = value;
      else grid_h = value;
      col_pos        = 0;
      row_pos        = 0;
      stencil_window = '0;
   endfunction

   // Push one cell through the stencil; an interior cell one up and one left
   // becomes complete once the incoming cell is at column >= 2 and row >= 2.
   function automatic void step_stencil(input logic alive);
      int unsigned     w, h, c, r, cnt;
      logic            top, mid;
      logic [2:0]      fresh, left, centre;
      cell_result_type res;
      w = clamp_size(grid_w);
      h = clamp_size(grid_h);
      c = (col_pos >= w) ? w - 1 : col_pos;
      r = (row_pos >= h) ? h - 1 : row_pos;
      top            = line_upper[c];
      mid            = line_middle[c];
      line_upper[c]  = mid;
      line_middle[c] = alive;
      fresh  = {alive, mid, top};
      left   = stencil_window[2:0];
      centre = stencil_window[5:3];
      if (c >= 2 && r >= 2) begin
         // centre counts eight times, so 10 and 11 mean alive with two or three neighbours
         cnt = int'(left[0]) + int'(left[1]) + int'(left[2])
             + int'(fresh[0]) + int'(fresh[1]) + int'(fresh[2])
             + int'(centre[0]) + int'(centre[2]) + CENTRE_WEIGHT * int'(centre[1]);
         res.next_alive = (cnt == 3 || cnt == 10 || cnt == 11);
         res.green      = GREEN_LUT[cnt*GREEN_W +: GREEN_W];
         res.column     = COORD_W'(c - 1);
         res.row        = COORD_W'(r - 1);
         res.last       = (c == w - 1 && r == h - 1);
         due_cells.push_back(res);
      end
      stencil_window = {fresh, centre};
      if (c + 1 >= w) begin
         col_pos = 0;
         row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
         row_pos = r;
      end
   endfunction

   function automatic int unsigned draw_wait(input bit calm);
      if (calm) return 0;
      return $urandom_range(0, WAIT_MAX);
   endfunction

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t %s: expected %0h, got %0h", $time, field, want, got);
         failed = 1'b1;
      end
   endtask

   // ---------------------------------------------------------------- cell driver
   // Presents the next word once the previous one has gone, after its drawn gap.
   // Calm stretches toggle now and then so that back-to-back runs occur too.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_hold = 0;
      end else if (!req_valid || req_taken) begin
         if (req_hold != 0) begin
            req_valid <= 1'b0;
            req_hold--;
         end else if (cell_queue.size() != 0) begin
            req_valid      <= 1'b1;
            req_cell_alive <= cell_queue.pop_front();
            req_hold = draw_wait(req_calm);
            if ($urandom_range(0, 63) == 0) req_calm = !req_calm;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- result sink
   // Stall runs independently of rsp_valid, so it lands on every phase of the pipe.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_taken) begin
            stall_left = draw_wait(rsp_calm);
            if ($urandom_range(0, 63) == 0) rsp_calm = !rsp_calm;
         end
         rsp_stall <= (stall_left != 0);
         if (stall_left != 0) stall_left--;
      end
   end

   // ---------------------------------------------------------------- monitor
   always @(posedge clock) begin
      cell_result_type want;
      req_taken <= !reset && req_valid && !req_stall;
      rsp_taken <= !reset && rsp_valid && !rsp_stall;
      if (!reset && req_valid && !req_stall) begin
         step_stencil(req_cell_alive);
         cells_taken++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_cells.size() == 0) begin
            $display("%0t unexpected result word: expected none, got col %0d row %0d",
                     $time, rsp_cell_column, rsp_cell_row);
            failed = 1'b1;
         end else begin
            want = due_cells.pop_front();
            check_field("next_alive",  32'(want.next_alive), 32'(rsp_next_alive));
            check_field("green_level", 32'(want.green),      32'(rsp_green_level));
            check_field("cell_column", 32'(want.column),     32'(rsp_cell_column));
            check_field("cell_row",    32'(want.row),        32'(rsp_cell_row));
            check_field("frame_last",  32'(want.last),       32'(rsp_frame_last));
         end
      end
   end

   // ---------------------------------------------------------------- stimulus
   task automatic push_cells(input int unsigned count, input int unsigned density);
      repeat (count) begin
         cell_queue.push_back($urandom_range(0, 99) < density);
         cells_sent++;
      end
   endtask

   // 3x3 pattern, bit i is raster cell i
   task automatic push_pattern(input logic [8:0] bits);
      for (int i = 0; i < 9; i++) begin
         cell_queue.push_back(bits[i]);
         cells_sent++;
      end
   endtask

   // Wait for the block to drain; edge cells may still be in flight with nothing owed
   task automatic settle();
      while (cells_taken != cells_sent || due_cells.size() != 0) @(negedge clock);
      repeat (SETTLE_TICKS) @(negedge clock);
   endtask

   // Called at a falling edge; returns at a falling edge with csr_valid low
   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_reg(idx, value);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   int unsigned densities[5] = '{8, 30, 50, 70, 92};

   initial begin
      int unsigned pick, eff_w, eff_h, gens, density, rand_cells;
      logic [CSR_DATA_W-1:0] w_val, h_val;

      grid_w = CSR_DATA_W'(GRID_MAX);
      grid_h = CSR_DATA_W'(GRID_MAX);
      col_pos = 0;
      row_pos = 0;
      stencil_window = '0;
      foreach (line_upper[i]) begin
         line_upper[i]  = 1'b0;
         line_middle[i] = 1'b0;
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // a few words at the reset size: first row only, so nothing comes back
      push_cells(3, 50);
      settle();

      // smallest grid: a single interior cell per generation
      write_reg(CSR_GRID_WIDTH, CSR_DATA_W'(3));
      write_reg(CSR_GRID_HEIGHT, CSR_DATA_W'(3));
      push_pattern(9'h1FF);            // all alive, count at its top
      push_pattern(9'b101000010);      // dead centre, three neighbours: birth
      push_pattern(9'b100010001);      // live centre, two neighbours: survival
      settle();

      // tall column, register values clamped from both ends; top part only
      write_reg(CSR_GRID_WIDTH, 11'd0);
      write_reg(CSR_GRID_HEIGHT, 11'd1025);
      push_cells(3 * TALL_ROWS, 50);
      settle();

      // random phases: small grids, whole generations, sometimes cut short by a write
      rand_cells = 0;
      while (rand_cells < RANDOM_CELLS) begin
         pick = $urandom_range(0, 19);
         if (pick < 15) w_val = CSR_DATA_W'($urandom_range(3, 12));
         else if (pick < 18) w_val = CSR_DATA_W'($urandom_range(13, 24));
         else w_val = CSR_DATA_W'($urandom_range(0, 2));
         pick = $urandom_range(0, 19);
         if (pick < 15) h_val = CSR_DATA_W'($urandom_range(3, 10));
         else if (pick < 18) h_val = CSR_DATA_W'($urandom_range(11, 20));
         else h_val = CSR_DATA_W'($urandom_range(0, 2));

         pick = $urandom_range(0, 3);
         if (pick != 1) write_reg(CSR_GRID_WIDTH, w_val);
         if (pick != 0) write_reg(CSR_GRID_HEIGHT, h_val);
         eff_w = clamp_size(grid_w);
         eff_h = clamp_size(grid_h);

         gens = $urandom_range(1, 3);
         repeat (gens) begin
            if (rand_cells < RANDOM_CELLS) begin
               density = densities[$urandom_range(0, 4)];
               push_cells(eff_w * eff_h, density);
               rand_cells += eff_w * eff_h;
            end
         end
         if ($urandom_range(0, 3) == 0) begin
            // abandoned generation, the next write restarts it
            pick = $urandom_range(1, eff_w * eff_h - 1);
            push_cells(pick, densities[$urandom_range(0, 4)]);
            rand_cells += pick;
         end
         settle();
      end

      if (!failed) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #20_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

// File: sim.f
hdl/lgs_pkg.sv
hdl/lgs_ram.sv
hdl/lgs_stencil.sv
hdl/life_generation_stencil.sv
sim/tb.sv
